@@ rtl/median_soil_moisture_calibrator_macros.svh @@
// -----------------------------------------------------------------------------
// median_soil_moisture_calibrator_macros.svh
// Assertion macros used by the checker of the calibrator.
// -----------------------------------------------------------------------------
`ifndef MEDIAN_SOIL_MOISTURE_CALIBRATOR_MACROS_SVH
`define MEDIAN_SOIL_MOISTURE_CALIBRATOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MSMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calibrator check failed");

// Property checked on every clock edge, reset included.
`define MSMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("calibrator reset check failed");

`endif

@@ rtl/msmc_pkg.sv @@
// -----------------------------------------------------------------------------
// msmc_pkg
// Types and constants of the soil moisture median calibrator.
// -----------------------------------------------------------------------------
package msmc_pkg;

  localparam int ADC_W     = 12;
  localparam int MOIST_W   = 10;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 1;

  // Divider operand widths: |(median - dry) * 1000| < 2**22, |wet - dry| < 2**12
  localparam int NUM_W = 22;
  localparam int DEN_W = 12;

  localparam logic [MOIST_W-1:0] MOIST_MAX = 10'd1000;
  localparam logic [ADC_W-1:0]   DRY_RESET = 12'd3200;
  localparam logic [ADC_W-1:0]   WET_RESET = 12'd1400;

  localparam logic [CFG_IDX_W-1:0] REG_DRY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET = 1'd1;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_LOAD_CAND,
    ST_LATCH_CAND,
    ST_SWEEP,
    ST_CHECK,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/msmc_sample_mem.sv @@
// -----------------------------------------------------------------------------
// msmc_sample_mem
// Batch sample store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module msmc_sample_mem #(
  parameter int DEPTH = 11
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [msmc_pkg::ADC_W-1:0]     wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [msmc_pkg::ADC_W-1:0]     rdata
);

  logic [msmc_pkg::ADC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/msmc_div.sv @@
// -----------------------------------------------------------------------------
// msmc_div
// Unsigned restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module msmc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [msmc_pkg::NUM_W-1:0]    num,
  input  logic [msmc_pkg::DEN_W-1:0]    den,
  output msmc_pkg::div_stat_t           stat,
  output logic [msmc_pkg::NUM_W-1:0]    quot
);

  localparam int NW = msmc_pkg::NUM_W;
  localparam int DW = msmc_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [NW-1:0] qsh;

  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    shifted  = {rem, qsh[NW-1]};
    trial    = shifted - {1'b0, den_r};
    ge       = (shifted >= {1'b0, den_r});
    rem_next = ge ? trial[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      qsh   <= num;
    end else if (busy) begin
      rem <= rem_next;
      qsh <= {qsh[NW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = qsh;

endmodule

@@ rtl/median_soil_moisture_calibrator.sv @@
// -----------------------------------------------------------------------------
// median_soil_moisture_calibrator
// Batch median of soil converter samples with linear dry/wet calibration.
// -----------------------------------------------------------------------------
// Samples are taken one per cycle while the block collects, written into an
// on-chip store. After SAMPLE_COUNT samples the input stalls while the median
// is found by rank counting over the store: each candidate costs one sweep
// through the single read port. Scaling, the bit-serial divider (skipped when
// the span is zero, the signs differ or the numerator is zero) and the hand-off
// to the output register follow, and the input is ready again in the same
// cycle that the batch's result becomes valid, so no sample of the next batch
// is taken before that hand-off.
// One result item leaves per batch through an output register; a held result
// blocks the hand-off of the next batch's result, and the input stays stalled
// until that hand-off.
module median_soil_moisture_calibrator #(
  parameter int SAMPLE_COUNT = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: [11:0] adc_sample
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [msmc_pkg::S_TDATA_W-1:0]    s_tdata,
  // m_tdata: [11:0] median_raw, [21:12] moisture_tenths, [22] calib_error
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [msmc_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [msmc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [msmc_pkg::ADC_W-1:0]        cfg_data
);

  localparam int IW   = $clog2(SAMPLE_COUNT);
  localparam int CW   = $clog2(SAMPLE_COUNT + 1);
  localparam int MID  = SAMPLE_COUNT / 2;
  localparam int LAST = SAMPLE_COUNT - 1;
  localparam int AW   = msmc_pkg::ADC_W;
  localparam int MW   = msmc_pkg::MOIST_W;
  localparam int NW   = msmc_pkg::NUM_W;
  localparam int DW   = msmc_pkg::DEN_W;

  msmc_pkg::state_t state, state_next;

  logic [AW-1:0]        dry_reading;
  logic [AW-1:0]        wet_reading;
  logic [IW-1:0]        fill_count;
  logic [IW-1:0]        cand_idx;
  logic [IW-1:0]        cmp_idx;
  logic [AW-1:0]        cand;
  logic [CW-1:0]        cnt_lt;
  logic [CW-1:0]        cnt_le;
  logic [AW-1:0]        median;
  logic signed [NW:0]   num;
  logic signed [DW:0]   den;
  logic [MW-1:0]        res_moist;
  logic                 res_err;
  logic                 out_valid;
  logic [AW-1:0]        out_median;
  logic [MW-1:0]        out_moist;
  logic                 out_err;

  logic                 mem_we;
  logic [IW-1:0]        mem_raddr;
  logic [AW-1:0]        mem_rdata;
  logic                 found;
  logic                 out_free;
  logic signed [DW:0]   diff;
  logic signed [NW:0]   diff_ext;
  logic                 neg;
  logic                 skip_div;
  logic [NW:0]          num_abs;
  logic [DW:0]          den_abs;
  logic                 div_start;
  msmc_pkg::div_stat_t  div_stat;
  logic [NW-1:0]        div_quot;

  msmc_sample_mem #(
    .DEPTH (SAMPLE_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_count),
    .wdata (s_tdata[AW-1:0]),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  msmc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_abs[NW-1:0]),
    .den   (den_abs[DW-1:0]),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Candidate is the median when at most MID samples lie below it and more
  // than MID lie at or below it.
  assign found    = (cnt_lt <= CW'(MID)) && (cnt_le > CW'(MID));
  assign out_free = !out_valid || m_tready;

  always_comb begin
    diff     = $signed({1'b0, median}) - $signed({1'b0, dry_reading});
    diff_ext = (NW + 1)'(diff);
    neg      = num[NW] ^ den[DW];
    num_abs  = num[NW] ? (NW + 1)'(-num) : (NW + 1)'(num);
    den_abs  = den[DW] ? (DW + 1)'(-den) : (DW + 1)'(den);
    skip_div = (den == '0) || neg || (num == '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      msmc_pkg::ST_COLLECT: begin
        if (s_tvalid && (fill_count == IW'(LAST))) begin
          state_next = msmc_pkg::ST_LOAD_CAND;
        end
      end
      msmc_pkg::ST_LOAD_CAND:  state_next = msmc_pkg::ST_LATCH_CAND;
      msmc_pkg::ST_LATCH_CAND: state_next = msmc_pkg::ST_SWEEP;
      msmc_pkg::ST_SWEEP: begin
        if (cmp_idx == IW'(LAST)) begin
          state_next = msmc_pkg::ST_CHECK;
        end
      end
      msmc_pkg::ST_CHECK: begin
        state_next = found ? msmc_pkg::ST_SCALE : msmc_pkg::ST_LOAD_CAND;
      end
      msmc_pkg::ST_SCALE: state_next = msmc_pkg::ST_DIV_START;
      msmc_pkg::ST_DIV_START: begin
        state_next = skip_div ? msmc_pkg::ST_FINISH : msmc_pkg::ST_DIV_WAIT;
      end
      msmc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = msmc_pkg::ST_FINISH;
        end
      end
      msmc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = msmc_pkg::ST_COLLECT;
        end
      end
      default: state_next = msmc_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    s_tready  = (state == msmc_pkg::ST_COLLECT);
    mem_we    = (state == msmc_pkg::ST_COLLECT) && s_tvalid;
    div_start = (state == msmc_pkg::ST_DIV_START) && !skip_div;
    case (state)
      msmc_pkg::ST_LOAD_CAND: mem_raddr = cand_idx;
      msmc_pkg::ST_SWEEP: begin
        // prefetch the next entry; past the end, park the address at zero
        mem_raddr = (cmp_idx == IW'(LAST)) ? '0 : cmp_idx + IW'(1);
      end
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= msmc_pkg::ST_COLLECT;
      fill_count  <= '0;
      dry_reading <= msmc_pkg::DRY_RESET;
      wet_reading <= msmc_pkg::WET_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          msmc_pkg::REG_DRY: dry_reading <= cfg_data;
          msmc_pkg::REG_WET: wet_reading <= cfg_data;
          default: ;
        endcase
      end
      if (mem_we) begin
        fill_count <= (fill_count == IW'(LAST)) ? '0 : fill_count + IW'(1);
      end
      if (state == msmc_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      msmc_pkg::ST_COLLECT: cand_idx <= '0;
      msmc_pkg::ST_LATCH_CAND: begin
        cand    <= mem_rdata;
        cmp_idx <= '0;
        cnt_lt  <= '0;
        cnt_le  <= '0;
      end
      msmc_pkg::ST_SWEEP: begin
        cmp_idx <= cmp_idx + IW'(1);
        cnt_lt  <= cnt_lt + CW'(mem_rdata < cand);
        cnt_le  <= cnt_le + CW'(mem_rdata <= cand);
      end
      msmc_pkg::ST_CHECK: begin
        if (found) begin
          median <= cand;
        end else begin
          cand_idx <= cand_idx + IW'(1);
        end
      end
      msmc_pkg::ST_SCALE: begin
        num <= diff_ext * 23'sd1000;
        den <= $signed({1'b0, wet_reading}) - $signed({1'b0, dry_reading});
      end
      msmc_pkg::ST_DIV_START: begin
        res_moist <= '0;
        res_err   <= (den == '0);
      end
      msmc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          res_moist <= (div_quot > NW'(msmc_pkg::MOIST_MAX))
                       ? msmc_pkg::MOIST_MAX : div_quot[MW-1:0];
        end
      end
      msmc_pkg::ST_FINISH: begin
        if (out_free) begin
          out_median <= median;
          out_moist  <= res_moist;
          out_err    <= res_err;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_err, out_moist, out_median};

endmodule

@@ rtl/msmc_checker.sv @@
// -----------------------------------------------------------------------------
// msmc_checker
// Port-level checks of the soil moisture calibrator, bound to the top level.
// -----------------------------------------------------------------------------
`include "median_soil_moisture_calibrator_macros.svh"

module msmc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [msmc_pkg::M_TDATA_W-1:0]    m_tdata
);

  // a stalled result item holds
  `MSMC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // moisture never leaves its clamp range
  `MSMC_ASSERT(a_moist_range, m_tvalid |-> m_tdata[21:12] <= 10'd1000)

  // a calibration error always reports zero moisture
  `MSMC_ASSERT(a_err_zero, m_tvalid && m_tdata[22] |-> m_tdata[21:12] == 10'd0)

  // reset leaves the block collecting with no result pending
  `MSMC_ASSERT_ALWAYS(a_reset_state, rst |=> s_tready && !m_tvalid)

endmodule

bind median_soil_moisture_calibrator msmc_checker u_msmc_checker (.*);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream test of the soil moisture median calibrator.
// ----------------------------------------------------------------------------
// Samples go in one item at a time. After every full batch a local model sorts
// the batch, picks the middle sample and scales it between the dry and wet
// points. Each result item is checked field by field against the oldest
// prediction. Both sides stall at random but in the last phase, and the
// calibration points move through extreme, inverted, equal and random settings between phases.
`timescale 1ns / 100ps

module tb;

  localparam int SAMPLE_COUNT  = 11;
  // Rank search, scaling and the serial divide after the last item of a batch.
  localparam int BATCH_LATENCY = SAMPLE_COUNT * (SAMPLE_COUNT + 3) + 28;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SEG_ITEMS     = 90;
  localparam int SEGS_PER_MODE = 5;

  typedef struct packed {
    logic                         calib_error;
    logic [msmc_pkg::MOIST_W-1:0] moisture;
    logic [msmc_pkg::ADC_W-1:0]   median;
  } reading_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [msmc_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [msmc_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           cfg_we = 1'b0;
  logic [msmc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [msmc_pkg::ADC_W-1:0]     cfg_data = '0;

  // Calibration and batch model
  logic [msmc_pkg::ADC_W-1:0] cal_dry = msmc_pkg::DRY_RESET;
  logic [msmc_pkg::ADC_W-1:0] cal_wet = msmc_pkg::WET_RESET;
  logic [msmc_pkg::ADC_W-1:0] batch_buf [SAMPLE_COUNT];
  int                         batch_fill = 0;
  reading_t                   pending_readings [$];

  int src_idle_pct  = 26;
  int sink_idle_pct = 47;
  int mismatches    = 0;
  int cycle_count   = 0;
  int setting_no    = 0;

  median_soil_moisture_calibrator #(.SAMPLE_COUNT(SAMPLE_COUNT)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL median_soil_moisture_calibrator");
      $finish;
    end
  end

  // Add one sample to the batch; a full batch yields one predicted reading.
  function automatic void absorb_sample(logic [msmc_pkg::ADC_W-1:0] sample);
    logic [msmc_pkg::ADC_W-1:0] sorted [SAMPLE_COUNT];
    logic [msmc_pkg::ADC_W-1:0] key;
    int                         j;
    int                         den;
    int                         num;
    int                         q;
    reading_t                   r;
    batch_buf[batch_fill] = sample;
    batch_fill++;
    if (batch_fill < SAMPLE_COUNT) return;
    batch_fill = 0;
    sorted = batch_buf;
    for (int i = 1; i < SAMPLE_COUNT; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    r.median = sorted[SAMPLE_COUNT / 2];
    den = int'(cal_wet) - int'(cal_dry);
    if (den == 0) begin
      r.calib_error = 1'b1;
      r.moisture = '0;
    end else begin
      num = (int'(r.median) - int'(cal_dry)) * 1000;
      q = num / den;
      if (q < 0) q = 0;
      if (q > 1000) q = 1000;
      r.calib_error = 1'b0;
      r.moisture = q[msmc_pkg::MOIST_W-1:0];
    end
    pending_readings.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = reading_t'(m_tdata[$bits(reading_t)-1:0]);
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result, median", got.median, 0);
      end else begin
        want = pending_readings.pop_front();
        if (got.median !== want.median)
          report_mismatch("median_raw", got.median, want.median);
        if (got.moisture !== want.moisture)
          report_mismatch("moisture_tenths", got.moisture, want.moisture);
        if (got.calib_error !== want.calib_error)
          report_mismatch("calib_error", got.calib_error, want.calib_error);
      end
    end
  end

  // Present one sample, hold it until taken, then update the model.
  task automatic send_sample(logic [msmc_pkg::ADC_W-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= msmc_pkg::S_TDATA_W'(sample);
    do @(posedge clk); while (!(s_tvalid && s_tready));
    absorb_sample(sample);
  endtask

  // Drop valid, drain all results and let any batch in flight finish.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (BATCH_LATENCY) @(posedge clk);
  endtask

  task automatic write_cal(logic [msmc_pkg::CFG_IDX_W-1:0] idx,
                           logic [msmc_pkg::ADC_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == msmc_pkg::REG_DRY) cal_dry = value;
    else if (idx == msmc_pkg::REG_WET) cal_wet = value;
  endtask

  function automatic logic [msmc_pkg::ADC_W-1:0] draw_sample();
    int lo;
    int hi;
    int sel;
    lo = (cal_dry < cal_wet) ? int'(cal_dry) : int'(cal_wet);
    hi = (cal_dry < cal_wet) ? int'(cal_wet) : int'(cal_dry);
    lo = (lo > 200) ? lo - 200 : 0;
    hi = (hi < 3895) ? hi + 200 : 4095;
    sel = $urandom_range(9);
    if (sel <= 5) return msmc_pkg::ADC_W'($urandom_range(hi, lo));
    if (sel <= 7) return msmc_pkg::ADC_W'($urandom());
    if (sel == 8) return $urandom_range(1) ? cal_dry : cal_wet;
    return $urandom_range(1) ? 12'hFFF : 12'h000;
  endfunction

  // Median at full scale against the reset points: negative slope clamps to 0.
  task automatic test_extreme_samples();
    for (int i = 0; i < SAMPLE_COUNT; i++)
      send_sample((i % 2 == 0) ? 12'hFFF : 12'h000);
  endtask

  task automatic test_equal_calibration();
    logic [msmc_pkg::ADC_W-1:0] mix [SAMPLE_COUNT] = '{12'hAAA, 12'h555, 12'h800,
      12'h7FF, 12'h000, 12'hFFF, 12'h001, 12'hFFE, 12'h123, 12'hEDC, 12'h800};
    settle();
    write_cal(msmc_pkg::REG_DRY, 12'h800);
    write_cal(msmc_pkg::REG_WET, 12'h800);
    foreach (mix[i]) send_sample(mix[i]);
  endtask

  // Leave a partial batch open across a calibration change.
  task automatic test_midbatch_write();
    send_sample(12'h001);
    send_sample(12'hFFE);
    send_sample(12'h800);
    settle();
    write_cal(msmc_pkg::REG_WET, 12'h000);
    write_cal(msmc_pkg::REG_DRY, 12'hFFF);
  endtask

  task automatic apply_next_setting();
    logic [msmc_pkg::ADC_W-1:0] a;
    a = msmc_pkg::ADC_W'($urandom());
    case (setting_no % 7)
      0: begin
        write_cal(msmc_pkg::REG_DRY, 12'h000);
        write_cal(msmc_pkg::REG_WET, 12'hFFF);
      end
      1: begin
        write_cal(msmc_pkg::REG_DRY, 12'hFFF);
        write_cal(msmc_pkg::REG_WET, 12'h000);
      end
      2: begin
        write_cal(msmc_pkg::REG_DRY, a);
        write_cal(msmc_pkg::REG_WET, a);
      end
      3: begin
        a = $urandom_range(1) ? 12'hFFF : 12'h000;
        write_cal(msmc_pkg::REG_WET, a);
        write_cal(msmc_pkg::REG_DRY, a);
      end
      4: begin
        write_cal(msmc_pkg::REG_WET, msmc_pkg::ADC_W'($urandom()));
        write_cal(msmc_pkg::REG_DRY, a);
      end
      5: begin
        write_cal(msmc_pkg::REG_DRY, msmc_pkg::DRY_RESET);
        write_cal(msmc_pkg::REG_WET, msmc_pkg::WET_RESET);
      end
      default: begin
        // one-count span: steep slope, nearly every median clamps
        write_cal(msmc_pkg::REG_DRY, a);
        write_cal(msmc_pkg::REG_WET, (a == 12'hFFF) ? a - 12'd1 : a + 12'd1);
      end
    endcase
    setting_no++;
  endtask

  task automatic test_random_settings(int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
      settle();
      apply_next_setting();
      for (int n = 0; n < SEG_ITEMS; n++) send_sample(draw_sample());
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_extreme_samples();
    test_equal_calibration();
    test_midbatch_write();
    test_random_settings(26, 47);
    test_random_settings(47, 26);
    test_random_settings(0, 0);
    settle();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("PASS median_soil_moisture_calibrator");
    end else begin
      $display("FAIL median_soil_moisture_calibrator");
    end
    $finish;
  end

endmodule
